// ===== design/tcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker package
// Shared widths, types and constants for the transfer chunker block.
// ----------------------------------------------------------------------------
package tcbp_pkg;
   localparam int NumBuffersDefault  = 8;
   localparam int RecordDepthDefault = 16;
   localparam int MaxResults         = 8;

   localparam int AddrW  = 48;
   localparam int LenW   = 40;
   localparam int MachW  = 16;
   localparam int BufW   = 3;
   localparam int BytesW = 31;
   localparam int EntW   = 7;
   localparam int MbW    = 11;

   localparam logic [10:0] BufferMbytesReset = 11'd4;
   localparam logic [30:0] EntryBytesReset   = 31'd1048576;
   localparam logic [6:0]  MaxEntriesReset   = 7'd4;

   localparam logic [1:0] CsrBufferMbytes = 2'd0;
   localparam logic [1:0] CsrEntryBytes   = 2'd1;
   localparam logic [1:0] CsrMaxEntries   = 2'd2;

   localparam logic ReqWrite  = 1'b0;
   localparam logic ReqReturn = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACCEPT, ST_DECIDE, ST_OPEN_RD, ST_OPEN, ST_CALC,
      ST_DIV, ST_EMIT, ST_REFUSE, ST_WAIT, ST_FLUSH
   } state_type;

   typedef struct packed {
      logic push_rec;
      logic push_buf;
      logic load_open;
      logic calc;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rec_full;
      logic rec_empty;
      logic buf_empty;
      logic open_exhausted;
      logic div_busy;
      logic chunk_done;
   } sts_type;
endpackage

// ===== design/tcbp_if.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker channel interfaces
// Request, response and CSR valid/ready channels.
// ----------------------------------------------------------------------------
interface tcbp_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [47:0] req_src_addr;
   logic [39:0] req_length;
   logic [39:0] req_start_offset;
   logic [15:0] req_machine_id;
   logic [2:0]  freed_buffer;
   modport source (output valid, req_type, req_src_addr, req_length, req_start_offset,
                   req_machine_id, freed_buffer, input ready);
   modport sink   (input valid, req_type, req_src_addr, req_length, req_start_offset,
                   req_machine_id, freed_buffer, output ready);
endinterface

interface tcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  chunk_buffer;
   logic [15:0] chunk_machine_id;
   logic [47:0] chunk_src_addr;
   logic [30:0] chunk_bytes;
   logic [6:0]  chunk_entries;
   logic        record_done;
   logic        refused;
   logic        last;
   modport source (output valid, chunk_buffer, chunk_machine_id, chunk_src_addr,
                   chunk_bytes, chunk_entries, record_done, refused, last, input ready);
   modport sink   (input valid, chunk_buffer, chunk_machine_id, chunk_src_addr,
                   chunk_bytes, chunk_entries, record_done, refused, last, output ready);
endinterface

interface tcbp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tcbp_datapath.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker datapath
// Record store, buffer pool, open record, chunk sizing and entry divider.
// ----------------------------------------------------------------------------
module tcbp_datapath #(
   parameter int NUM_BUFFERS  = 8,
   parameter int RECORD_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  tcbp_pkg::cmd_type  cmd,
   output tcbp_pkg::sts_type  sts,
   input  logic [47:0]        in_addr,
   input  logic [39:0]        in_length,
   input  logic [39:0]        in_offset,
   input  logic [15:0]        in_machine,
   input  logic [2:0]         in_buffer,
   input  logic [10:0]        buffer_mbytes,
   input  logic [30:0]        entry_bytes,
   input  logic [6:0]         max_entries,
   output logic [2:0]         out_buffer,
   output logic [15:0]        out_machine,
   output logic [47:0]        out_addr,
   output logic [30:0]        out_bytes,
   output logic [6:0]         out_entries,
   output logic               out_done
);
   import tcbp_pkg::*;

   localparam int RecAw = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
   localparam int BufAw = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int RecCw = $clog2(RECORD_DEPTH + 1);
   localparam int BufCw = $clog2(NUM_BUFFERS + 1);
   localparam int RecW  = AddrW + LenW + LenW + MachW;

   // Record store: memory with registered read.
   logic [RecW-1:0]  rec_mem [RECORD_DEPTH];
   logic [RecW-1:0]  rec_rd_ff;
   logic [RecAw-1:0] rec_head_ff, rec_tail_ff;
   logic [RecCw-1:0] rec_count_ff;

   // Buffer pool: small register array read at the head only.
   logic [BufW-1:0]  pool_ff [NUM_BUFFERS];
   logic [BufAw-1:0] pool_head_ff, pool_tail_ff;
   logic [BufCw-1:0] pool_count_ff;

   logic [AddrW-1:0] open_addr_ff;
   logic [LenW-1:0]  open_len_ff, open_off_ff;
   logic [MachW-1:0] open_mach_ff;

   logic [BytesW-1:0] tb_ff;
   logic [30:0]       quo_ff, rem_ff, dvd_ff, dvs_ff;
   logic [4:0]        div_cnt_ff;
   logic              div_busy_ff;

   logic [LenW-1:0]  left;
   logic [LenW-1:0]  cap;
   logic [LenW-1:0]  new_off;
   logic             buf_ok;
   logic [31:0]      trial;

   function automatic logic [RecAw-1:0] rec_inc(input logic [RecAw-1:0] v);
      rec_inc = ({1'b0, v} + 1'b1 >= (RecAw+1)'(RECORD_DEPTH)) ? '0 : v + 1'b1;
   endfunction
   function automatic logic [BufAw-1:0] buf_inc(input logic [BufAw-1:0] v);
      buf_inc = ({1'b0, v} + 1'b1 >= (BufAw+1)'(NUM_BUFFERS)) ? '0 : v + 1'b1;
   endfunction

   assign left    = open_len_ff - open_off_ff;
   assign cap     = {9'd0, (buffer_mbytes == '0) ? 11'd1 : buffer_mbytes, 20'd0};
   assign new_off = open_off_ff + {9'd0, tb_ff};
   assign buf_ok  = ({{(32-BufW){1'b0}}, in_buffer} < 32'(NUM_BUFFERS));
   assign trial   = {rem_ff, dvd_ff[30]} - {1'b0, dvs_ff};

   assign sts.rec_full       = (rec_count_ff == RecCw'(RECORD_DEPTH));
   assign sts.rec_empty      = (rec_count_ff == '0);
   assign sts.buf_empty      = (pool_count_ff == '0);
   assign sts.open_exhausted = (open_off_ff >= open_len_ff);
   assign sts.div_busy       = div_busy_ff;
   assign sts.chunk_done     = (new_off >= open_len_ff);

   always_ff @(posedge clock) begin
      if (cmd.push_rec) begin
         rec_mem[rec_tail_ff] <= {in_addr, in_length, in_offset, in_machine};
      end
      rec_rd_ff <= rec_mem[rec_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_head_ff   <= '0;
         rec_tail_ff   <= '0;
         rec_count_ff  <= '0;
         pool_head_ff  <= '0;
         pool_tail_ff  <= '0;
         pool_count_ff <= BufCw'(NUM_BUFFERS);
         for (int i = 0; i < NUM_BUFFERS; i++) pool_ff[i] <= BufW'(i);
         open_addr_ff  <= '0;
         open_len_ff   <= '0;
         open_off_ff   <= '0;
         open_mach_ff  <= '0;
         div_busy_ff   <= 1'b0;
      end else begin
         if (cmd.push_rec) begin
            rec_tail_ff  <= rec_inc(rec_tail_ff);
            rec_count_ff <= rec_count_ff + 1'b1;
         end
         if (cmd.push_buf && buf_ok && pool_count_ff != BufCw'(NUM_BUFFERS)) begin
            pool_ff[pool_tail_ff] <= in_buffer;
            pool_tail_ff  <= buf_inc(pool_tail_ff);
            pool_count_ff <= pool_count_ff + 1'b1;
         end
         if (cmd.load_open) begin
            {open_addr_ff, open_len_ff, open_off_ff, open_mach_ff} <= rec_rd_ff;
            rec_head_ff  <= rec_inc(rec_head_ff);
            rec_count_ff <= rec_count_ff - 1'b1;
         end
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && div_cnt_ff == 5'd30) begin
            div_busy_ff <= 1'b0;
         end
         if (cmd.emit) begin
            pool_head_ff  <= buf_inc(pool_head_ff);
            pool_count_ff <= pool_count_ff - 1'b1;
            open_off_ff   <= new_off;
         end
      end
   end

   // Chunk size, then restoring divide of (tb-1) by entry size, one bit a cycle.
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         tb_ff <= (left < cap) ? left[30:0] : cap[30:0];
      end
      if (cmd.div_start) begin
         dvd_ff     <= tb_ff - 1'b1;
         dvs_ff     <= (entry_bytes == '0) ? 31'd1 : entry_bytes;
         rem_ff     <= '0;
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         dvd_ff     <= {dvd_ff[29:0], 1'b0};
         if (!trial[31]) begin
            rem_ff <= trial[30:0];
            quo_ff <= {quo_ff[29:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[29:0], dvd_ff[30]};
            quo_ff <= {quo_ff[29:0], 1'b0};
         end
      end
   end

   assign out_buffer  = pool_ff[pool_head_ff];
   assign out_machine = open_mach_ff;
   assign out_addr    = open_addr_ff + {8'd0, open_off_ff};
   assign out_bytes   = tb_ff;
   assign out_entries = ({1'b0, quo_ff} + 32'd1 > {25'd0, max_entries}) ? max_entries
                        : EntW'(quo_ff + 31'd1);
   assign out_done    = sts.chunk_done;
endmodule

// ===== design/tcbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker controller
// Sequences intake, record opening, chunk sizing and result beats.
// ----------------------------------------------------------------------------
module tcbp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_type,
   output logic              in_ready,
   output logic              rsp_load,
   output logic              rsp_refuse,
   output logic              rsp_last,
   input  logic              rsp_free,
   output tcbp_pkg::cmd_type cmd,
   input  tcbp_pkg::sts_type sts
);
   import tcbp_pkg::*;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   logic      held_ff, held_in;
   logic [3:0] n_ff, n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         held_ff  <= 1'b0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         n_ff     <= n_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      held_in    = held_ff;
      n_in       = n_ff;
      cmd        = '0;
      in_ready   = 1'b0;
      rsp_load   = 1'b0;
      rsp_refuse = 1'b0;
      rsp_last   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               n_in = '0;
               if (in_type == ReqWrite && sts.rec_full) begin
                  state_in = ST_REFUSE;
               end else begin
                  cmd.push_rec = (in_type == ReqWrite);
                  cmd.push_buf = (in_type == ReqReturn);
                  state_in     = ST_DECIDE;
               end
            end
         end
         ST_REFUSE: begin
            if (rsp_free) begin
               rsp_load   = 1'b1;
               rsp_refuse = 1'b1;
               rsp_last   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            // The item ends here; a held chunk still has to go out with last.
            if (n_ff == 4'(MaxResults)) begin
               state_in = held_ff ? ST_FLUSH : ST_IDLE;
            end else if (!phase_ff) begin
               state_in = !sts.rec_empty ? ST_OPEN_RD : (held_ff ? ST_FLUSH : ST_IDLE);
            end else begin
               state_in = !sts.buf_empty ? ST_CALC : (held_ff ? ST_FLUSH : ST_IDLE);
            end
         end
         ST_OPEN_RD: state_in = ST_OPEN;
         ST_OPEN: begin
            cmd.load_open = 1'b1;
            state_in      = ST_ACCEPT;
         end
         ST_ACCEPT: begin
            phase_in = !sts.open_exhausted;
            state_in = ST_DECIDE;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!sts.div_busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // A new chunk follows, so the held one goes out without last.
            if (!held_ff || rsp_free) begin
               rsp_load = held_ff;
               cmd.emit = 1'b1;
               held_in  = 1'b1;
               n_in     = n_ff + 1'b1;
               if (sts.chunk_done) phase_in = 1'b0;
               state_in = ST_DECIDE;
            end
         end
         ST_FLUSH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_last = 1'b1;
               held_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== design/transfer_chunker_with_buffer_pool.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker with buffer pool
// Splits write requests into buffer-sized chunks using a pool of buffers.
// ----------------------------------------------------------------------------
// Usage: each req beat is a write request (req_type 0) or a buffer return
// (req_type 1). Write requests queue in a record store of RECORD_DEPTH; a
// request into a full store yields one rsp beat with refused set. After each
// beat the block emits up to eight chunks, one rsp beat each, while a record
// is open and a buffer is idle; last marks the final beat of the item.
// Each chunk goes through decide, size, divider start, the one-bit-a-cycle
// divider that computes the scatter-gather entry count, and emit. Opening a
// record from the store adds the read, load and accept steps.
// A computed chunk is held one stage until the controller knows whether
// another chunk follows, so last is always exact.
// req_ready is high only while the controller is idle, so one item is worked
// at a time. A stalled receiver holds the output beat and the controller
// waits for the register to drain before passing the held chunk on.
// Reset restores register defaults, empties the store and fills the pool with
// buffers 0 to NUM_BUFFERS-1. CSR writes are always accepted.
// ----------------------------------------------------------------------------
module transfer_chunker_with_buffer_pool
   import tcbp_pkg::*;
#(
   parameter int NUM_BUFFERS  = NumBuffersDefault,
   parameter int RECORD_DEPTH = RecordDepthDefault
) (
   input  logic clock,
   input  logic reset,
   tcbp_req_if.sink   req,
   tcbp_rsp_if.source rsp,
   tcbp_csr_if.sink   csr
);
   logic [10:0] buffer_mbytes_ff;
   logic [30:0] entry_bytes_ff;
   logic [6:0]  max_entries_ff;

   cmd_type cmd;
   sts_type sts;
   logic rsp_load, rsp_refuse, rsp_last, rsp_free;
   logic [2:0]  d_buf;
   logic [15:0] d_mach;
   logic [47:0] d_addr;
   logic [30:0] d_bytes;
   logic [6:0]  d_ent;
   logic        d_done;
   logic        valid_ff;

   // Chunk held until the next decision tells whether it is the last one.
   logic [2:0]  hold_buf_ff;
   logic [15:0] hold_mach_ff;
   logic [47:0] hold_addr_ff;
   logic [30:0] hold_bytes_ff;
   logic [6:0]  hold_ent_ff;
   logic        hold_done_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_mbytes_ff <= BufferMbytesReset;
         entry_bytes_ff   <= EntryBytesReset;
         max_entries_ff   <= MaxEntriesReset;
      end else if (csr.valid) begin
         unique case (csr.index)
            CsrBufferMbytes: buffer_mbytes_ff <= csr.data[10:0];
            CsrEntryBytes:   entry_bytes_ff   <= csr.data;
            CsrMaxEntries:   max_entries_ff   <= csr.data[6:0];
            default: ;
         endcase
      end
   end

   tcbp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_type(req.req_type), .in_ready(req.ready),
      .rsp_load, .rsp_refuse, .rsp_last, .rsp_free, .cmd, .sts
   );

   tcbp_datapath #(.NUM_BUFFERS(NUM_BUFFERS), .RECORD_DEPTH(RECORD_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_addr(req.req_src_addr), .in_length(req.req_length),
      .in_offset(req.req_start_offset), .in_machine(req.req_machine_id),
      .in_buffer(req.freed_buffer),
      .buffer_mbytes(buffer_mbytes_ff), .entry_bytes(entry_bytes_ff),
      .max_entries(max_entries_ff),
      .out_buffer(d_buf), .out_machine(d_mach), .out_addr(d_addr),
      .out_bytes(d_bytes), .out_entries(d_ent), .out_done(d_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         hold_buf_ff   <= d_buf;
         hold_mach_ff  <= d_mach;
         hold_addr_ff  <= d_addr;
         hold_bytes_ff <= d_bytes;
         hold_ent_ff   <= d_ent;
         hold_done_ff  <= d_done;
      end
   end

   assign rsp_free  = !valid_ff || rsp.ready;
   assign rsp.valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rsp_load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp.chunk_buffer     <= rsp_refuse ? '0 : hold_buf_ff;
         rsp.chunk_machine_id <= rsp_refuse ? '0 : hold_mach_ff;
         rsp.chunk_src_addr   <= rsp_refuse ? '0 : hold_addr_ff;
         rsp.chunk_bytes      <= rsp_refuse ? '0 : hold_bytes_ff;
         rsp.chunk_entries    <= rsp_refuse ? '0 : hold_ent_ff;
         rsp.record_done      <= rsp_refuse ? 1'b0 : hold_done_ff;
         rsp.refused          <= rsp_refuse;
         rsp.last             <= rsp_last;
      end
   end
endmodule

// ===== design/tcbp_checker.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker port checker
// Port-level properties of the result and request channels.
// ----------------------------------------------------------------------------
module tcbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_refused,
   input logic        rsp_last,
   input logic [30:0] rsp_bytes
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");
   a_refuse_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> rsp_last)
      else $error("refusal without last");
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |-> rsp_bytes == '0)
      else $error("refusal carries bytes");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");
endmodule

bind transfer_chunker_with_buffer_pool tcbp_checker u_tcbp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_refused(rsp.refused), .rsp_last(rsp.last), .rsp_bytes(rsp.chunk_bytes)
);

// ===== verif/transfer_chunker_with_buffer_pool_tb.sv =====
// ----------------------------------------------------------------------------
// Transfer chunker with buffer pool testbench
// Drives write requests and buffer returns with bursty timing, stalls the
// chunk channel on its own pattern, predicts every chunk and refusal in a
// behavioral model of the record store and buffer pool, and checks each
// result beat field by field across several register settings.
// ----------------------------------------------------------------------------
module transfer_chunker_with_buffer_pool_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcbp_pkg::*;

   localparam int NumBufs     = NumBuffersDefault;
   localparam int RecDepth    = RecordDepthDefault;
   localparam int WatchLimit  = 6000;
   localparam int SettleWait  = 400;
   localparam int PhaseItems  = 38;

   typedef struct {
      logic        kind;
      logic [47:0] addr;
      logic [39:0] len;
      logic [39:0] off;
      logic [15:0] mach;
      logic [2:0]  buf_num;
      bit          drain_first;
   } req_beat_type;

   typedef struct {
      logic [47:0] addr;
      logic [39:0] len;
      logic [39:0] off;
      logic [15:0] mach;
   } transfer_rec_type;

   typedef struct {
      logic [2:0]  buf_num;
      logic [15:0] mach;
      logic [47:0] addr;
      logic [30:0] bytes;
      logic [6:0]  entries;
      logic        done;
      logic        refused;
      logic        last;
   } chunk_type;

   logic clock;
   logic reset;

   tcbp_req_if req ();
   tcbp_rsp_if rsp ();
   tcbp_csr_if csr ();

   transfer_chunker_with_buffer_pool i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // Model state: register copies, the open transfer, the record store and
   // the pool of idle buffers.
   logic [10:0]      buf_mbytes;
   logic [30:0]      entry_size;
   logic [6:0]       entry_cap;
   bit               rec_open;
   transfer_rec_type open_rec;
   transfer_rec_type rec_store[$];
   logic [2:0]       idle_pool[$];

   req_beat_type req_backlog[$];
   chunk_type    chunk_expect[$];
   req_beat_type beat_held;
   int           error_count;
   int           quiet_cycles;
   int           burst_left;
   int           gap_left;
   int           stall_mode;
   int           stall_run;

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   // Works out the chunks that one accepted beat causes and queues them.
   task automatic predict_chunks(input req_beat_type it);
      chunk_type   c;
      logic [63:0] cap, left, tb, eb, ent;
      int          n;
      n = 0;
      if (it.kind == ReqWrite) begin
         if (rec_store.size() >= RecDepth) begin
            c = '{default: '0};
            c.refused = 1'b1;
            c.last = 1'b1;
            chunk_expect.push_back(c);
            return;
         end
         rec_store.push_back('{addr: it.addr, len: it.len, off: it.off, mach: it.mach});
      end else if (idle_pool.size() < NumBufs) begin
         idle_pool.push_back(it.buf_num);
      end
      while (n < MaxResults) begin
         if (!rec_open) begin
            if (rec_store.size() == 0) break;
            open_rec = rec_store.pop_front();
            // A record with nothing left to move is dropped silently.
            if (open_rec.off >= open_rec.len) continue;
            rec_open = 1'b1;
         end
         if (idle_pool.size() == 0) break;
         c = '{default: '0};
         c.buf_num = idle_pool.pop_front();
         cap = 64'(buf_mbytes == 0 ? 11'd1 : buf_mbytes) << 20;
         left = 64'(open_rec.len) - 64'(open_rec.off);
         tb = (left < cap) ? left : cap;
         eb = (entry_size == 0) ? 64'd1 : 64'(entry_size);
         ent = (tb - 1) / eb + 1;
         if (ent > 64'(entry_cap)) ent = 64'(entry_cap);
         c.mach = open_rec.mach;
         c.addr = open_rec.addr + 48'(open_rec.off);
         c.bytes = tb[30:0];
         c.entries = ent[6:0];
         open_rec.off = open_rec.off + tb[39:0];
         if (open_rec.off >= open_rec.len) begin
            c.done = 1'b1;
            rec_open = 1'b0;
         end
         chunk_expect.push_back(c);
         n++;
      end
      if (n > 0) chunk_expect[chunk_expect.size() - 1].last = 1'b1;
   endtask

   function automatic req_beat_type write_beat(logic [47:0] addr, logic [39:0] len,
                                               logic [39:0] off, logic [15:0] mach);
      return '{kind: ReqWrite, addr: addr, len: len, off: off, mach: mach,
               buf_num: 3'(0), drain_first: 1'b0};
   endfunction

   function automatic req_beat_type return_beat(logic [2:0] b);
      return '{kind: ReqReturn, addr: 48'({$urandom, $urandom}),
               len: 40'({$urandom, $urandom}), off: 40'({$urandom, $urandom}),
               mach: 16'($urandom), buf_num: b, drain_first: 1'b0};
   endfunction

   // Random beat sized against the current buffer size, so that records
   // mostly finish in one or two chunks and the store keeps moving.
   function automatic req_beat_type random_beat();
      logic [63:0] cap;
      logic [39:0] len, off;
      int          pick;
      cap = 64'(buf_mbytes == 0 ? 11'd1 : buf_mbytes) << 20;
      if ($urandom_range(0, 99) < 58) return return_beat(3'($urandom));
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         len = 40'($urandom_range(1, 32'(2 * cap)));
         off = 40'($urandom % 32'(len));
      end else if (pick == 8) begin
         len = 40'($urandom_range(0, 32'(cap)));
         off = len + 40'($urandom_range(0, 3));
      end else begin
         // Deep offsets into long records exercise the upper length bits.
         len = 40'({$urandom, $urandom});
         if (len < 40'(2 * cap)) len = 40'(2 * cap) + len;
         off = len - 40'($urandom_range(1, 32'(2 * cap)));
      end
      return write_beat(48'({$urandom, $urandom}), len, off, 16'($urandom));
   endfunction

   // Request driver: sends backlog beats in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left = 0;
      end else begin
         if (req.valid && req.ready) predict_chunks(beat_held);
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain_first && chunk_expect.size() != 0)) begin
               beat_held = req_backlog.pop_front();
               req.valid <= 1'b1;
               req.req_type <= beat_held.kind;
               req.req_src_addr <= beat_held.addr;
               req.req_length <= beat_held.len;
               req.req_start_offset <= beat_held.off;
               req.req_machine_id <= beat_held.mach;
               req.freed_buffer <= beat_held.buf_num;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Chunk monitor: the receiver alternates between always ready, random
   // ready and long stalls, and every accepted beat is checked in order.
   always @(posedge clock) begin
      chunk_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_mode = 0;
         stall_run = 20;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (chunk_expect.size() == 0) begin
               $display("%0t: unexpected chunk beat buffer=%0d bytes=%0d refused=%0b",
                        $realtime, rsp.chunk_buffer, rsp.chunk_bytes, rsp.refused);
               error_count++;
            end else begin
               e = chunk_expect.pop_front();
               if (rsp.chunk_buffer !== e.buf_num ||
                   rsp.chunk_machine_id !== e.mach ||
                   rsp.chunk_src_addr !== e.addr ||
                   rsp.chunk_bytes !== e.bytes ||
                   rsp.chunk_entries !== e.entries ||
                   rsp.record_done !== e.done ||
                   rsp.refused !== e.refused ||
                   rsp.last !== e.last) begin
                  $display("%0t: chunk mismatch expected buf=%0d mach=%h addr=%h bytes=%0d",
                           $realtime, e.buf_num, e.mach, e.addr, e.bytes,
                           " ent=%0d done=%0b refused=%0b last=%0b",
                           e.entries, e.done, e.refused, e.last);
                  $display("%0t: chunk mismatch actual   buf=%0d mach=%h addr=%h bytes=%0d",
                           $realtime, rsp.chunk_buffer, rsp.chunk_machine_id,
                           rsp.chunk_src_addr, rsp.chunk_bytes,
                           " ent=%0d done=%0b refused=%0b last=%0b",
                           rsp.chunk_entries, rsp.record_done, rsp.refused, rsp.last);
                  error_count++;
               end
            end
         end
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run = $urandom_range(5, 60);
         end else begin
            stall_run--;
         end
         case (stall_mode)
            0: begin
               rsp.ready <= 1'b1;
            end
            1: begin
               rsp.ready <= 1'($urandom);
            end
            default: begin
               rsp.ready <= (stall_run % 31 == 0);
            end
         endcase
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Register writes happen only while the block is quiet.
   task automatic write_csr(input logic [1:0] idx, input logic [30:0] val);
      csr.index <= idx;
      csr.data <= val;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         CsrBufferMbytes: begin
            buf_mbytes = val[10:0];
         end
         CsrEntryBytes: begin
            entry_size = val;
         end
         CsrMaxEntries: begin
            entry_cap = val[6:0];
         end
         default: begin
         end
      endcase
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every queued beat to go out and every chunk to come back,
   // then lets the block finish any record drops that give no result.
   task automatic settle();
      while (req_backlog.size() != 0 || req.valid || chunk_expect.size() != 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic program_regs(input logic [30:0] mb, input logic [30:0] eb,
                               input logic [30:0] me);
      settle();
      write_csr(CsrBufferMbytes, mb);
      write_csr(CsrEntryBytes, eb);
      write_csr(CsrMaxEntries, me);
   endtask

   task automatic queue_random(input int count);
      req_beat_type it;
      for (int i = 0; i < count; i++) begin
         it = random_beat();
         // One beat per phase holds off until the block has fully drained.
         if (i == count / 2) it.drain_first = 1'b1;
         req_backlog.push_back(it);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.req_type = ReqWrite;
      req.req_src_addr = '0;
      req.req_length = '0;
      req.req_start_offset = '0;
      req.req_machine_id = '0;
      req.freed_buffer = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = CsrBufferMbytes;
      csr.data = '0;
      quiet_cycles = 0;
      error_count = 0;
      buf_mbytes = BufferMbytesReset;
      entry_size = EntryBytesReset;
      entry_cap = MaxEntriesReset;
      rec_open = 1'b0;
      open_rec = '{default: '0};
      for (int b = 0; b < NumBufs; b++) idle_pool.push_back(3'(b));
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings: address wrap, empty and overrun
      // records, a return into a full pool, a deep offset into the longest
      // record, and a store that fills up while the pool is empty.
      req_backlog.push_back(write_beat('1, 40'd10485765, '0, '1));
      req_backlog.push_back(write_beat(48'h123456789abc, '0, '0, 16'h0001));
      req_backlog.push_back(write_beat(48'h0, 40'd100, 40'd200, 16'h8000));
      req_backlog.push_back(return_beat(3'd0));
      req_backlog.push_back(return_beat(3'd1));
      req_backlog.push_back(return_beat(3'd2));
      req_backlog.push_back(return_beat(3'd7));
      req_backlog.push_back(write_beat('0, '1, 40'hFFFF6FFFFF, '0));
      req_backlog.push_back(return_beat(3'd3));
      req_backlog.push_back(return_beat(3'd4));
      req_backlog.push_back(return_beat(3'd5));
      req_backlog.push_back(write_beat(48'h800000000000, 40'd37748736, '0, 16'h5a5a));
      for (int i = 0; i < RecDepth + 2; i++)
         req_backlog.push_back(write_beat(48'({$urandom, $urandom}),
                                          40'($urandom_range(1, 9000000)),
                                          '0, 16'($urandom)));
      queue_random(PhaseItems - 28);

      program_regs(31'd1, 31'd1, 31'd1);
      queue_random(PhaseItems);
      program_regs(31'd1024, 31'd1073741824, 31'd64);
      queue_random(PhaseItems);
      // Zero registers act as one byte per entry and one MiB per buffer.
      program_regs(31'd0, 31'd0, 31'd0);
      queue_random(PhaseItems);
      program_regs(31'h7FF, 31'h7FFFFFFF, 31'h7F);
      queue_random(PhaseItems);
      program_regs(31'd2, 31'd4096, 31'd127);
      queue_random(PhaseItems);
      program_regs(31'($urandom_range(1, 16)), 31'($urandom_range(1, 1 << 22)),
                   31'($urandom_range(1, 64)));
      queue_random(PhaseItems);
      settle();

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
